>>> src/ordered_list_insert_delete_core_assert.svh
// Assertion macros for the ordered list core.
// Included by the controller and the datapath; no other dependencies.
`ifndef ORDERED_LIST_INSERT_DELETE_CORE_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_CORE_ASSERT_SVH

// same-cycle implication
`define OLID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OLID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/olid_pkg.sv
// Shared types and codes for the ordered list core.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package olid_pkg;

   localparam int DATA_W   = 32;
   localparam int CMD_W    = 2;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] OP_INSERT_FRONT = 2'd0;
   localparam logic [CMD_W-1:0] OP_APPEND       = 2'd1;
   localparam logic [CMD_W-1:0] OP_DELETE       = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic apply;     // take the command beat and update the list
      logic advance;   // a listing beat was taken, rotate to the next entry
   } ctrl_cmd_type;

   typedef struct packed {
      logic at_last;   // current listing beat is the final one
   } dp_status_type;

endpackage

`default_nettype wire

>>> src/olid_ctrl.sv
// Controller for the ordered list core: accept a command, then run the listing.
// Depends on olid_pkg and ordered_list_insert_delete_core_assert.svh.
`default_nettype none
`include "ordered_list_insert_delete_core_assert.svh"

module olid_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire olid_pkg::dp_status_type status,
   output olid_pkg::ctrl_cmd_type      cmd
);
   import olid_pkg::*;

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_LIST = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_stall   = (state_ff != STATE_IDLE);
   assign rsp_valid   = (state_ff == STATE_LIST);
   assign cmd.apply   = req_valid && (state_ff == STATE_IDLE);
   assign cmd.advance = rsp_valid && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (req_valid) state_in = STATE_LIST;
         end
         STATE_LIST: begin
            if (cmd.advance && status.at_last) state_in = STATE_IDLE;
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `OLID_ASSERT_NEXT(a_cmd_starts_listing, clock, reset, req_valid && !req_stall, rsp_valid, "command beat not followed by listing")
   `OLID_ASSERT_NEXT(a_last_frees_input, clock, reset, rsp_valid && !rsp_stall && status.at_last, !req_stall, "input still stalled after final beat")
   `OLID_ASSERT_NEXT(a_listing_continues, clock, reset, rsp_valid && !rsp_stall && !status.at_last, rsp_valid, "listing ended early")

endmodule

`default_nettype wire

>>> src/olid_datapath.sv
// Datapath for the ordered list core: entry shift line, count, listing index.
// Depends on olid_pkg and ordered_list_insert_delete_core_assert.svh.
`default_nettype none
`include "ordered_list_insert_delete_core_assert.svh"

module olid_datapath #(
   parameter int CAPACITY = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire olid_pkg::ctrl_cmd_type                cmd,
   output olid_pkg::dp_status_type                    status,
   input  wire logic [olid_pkg::CMD_W-1:0]            req_command,
   input  wire logic signed [olid_pkg::DATA_W-1:0]    req_value,
   input  wire logic [olid_pkg::POS_W-1:0]            req_position,
   output logic signed [olid_pkg::DATA_W-1:0]         rsp_element,
   output logic                                       rsp_list_empty,
   output logic                                       rsp_last,
   output logic [olid_pkg::STATUS_W-1:0]              rsp_status
);
   import olid_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   logic signed [DATA_W-1:0] entry_ff [CAPACITY];
   logic signed [DATA_W-1:0] entry_in [CAPACITY];
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic [IW-1:0]            idx_ff;
   logic [IW-1:0]            idx_in;
   logic [STATUS_W-1:0]      status_ff;
   logic [STATUS_W-1:0]      status_in;

   logic          full;
   logic          empty;
   logic          pos_ok;
   logic [PW-1:0] pos_ext;
   logic [CW-1:0] last_ix;

   assign full    = (count_ff == CW'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign pos_ext = PW'(req_position);
   assign pos_ok  = (pos_ext < PW'(count_ff));
   assign last_ix = count_ff - CW'(1);

   assign status.at_last = empty || (CW'(idx_ff) == last_ix);

   always_comb begin
      entry_in  = entry_ff;
      count_in  = count_ff;
      status_in = status_ff;
      idx_in    = idx_ff;
      if (cmd.apply) begin
         idx_in    = '0;
         status_in = ST_DONE;
         case (req_command)
            OP_INSERT_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  entry_in[0] = req_value;
                  for (int i = 1; i < CAPACITY; i++) entry_in[i] = entry_ff[i-1];
                  count_in = count_ff + CW'(1);
               end
            end
            OP_APPEND: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  for (int i = 0; i < CAPACITY; i++) begin
                     if (CW'(i) == count_ff) entry_in[i] = req_value;
                  end
                  count_in = count_ff + CW'(1);
               end
            end
            OP_DELETE: begin
               if (!pos_ok) begin
                  status_in = ST_RANGE;
               end else begin
                  for (int i = 0; i < CAPACITY - 1; i++) begin
                     if (PW'(i) >= pos_ext) entry_in[i] = entry_ff[i+1];
                  end
                  count_in = count_ff - CW'(1);
               end
            end
            default: status_in = ST_DONE;
         endcase
      end else if (cmd.advance) begin
         // rotate the held entries by one; after count beats the order is restored
         if (!empty) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
               entry_in[i] = (CW'(i) == last_ix) ? entry_ff[0] : entry_ff[i+1];
            end
            entry_in[CAPACITY-1] = entry_ff[0];
         end
         idx_in = status.at_last ? '0 : idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff  <= entry_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_element    = empty ? '0 : entry_ff[0];
   assign rsp_list_empty = empty;
   assign rsp_last       = status.at_last;
   assign rsp_status     = status_ff;

   `OLID_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count above capacity")
   `OLID_ASSERT_NOW(a_idx_in_list, clock, reset, !empty, CW'(idx_ff) < count_ff, "listing index past count")
   `OLID_ASSERT_NEXT(a_rotate_keeps_count, clock, reset, cmd.advance && !cmd.apply, count_ff == $past(count_ff), "count changed during listing")

endmodule

`default_nettype wire

>>> src/ordered_list_insert_delete_core.sv
// Ordered list core: one command beat, then one result beat per held entry.
// First result beat is valid the cycle after the command beat; a listing has
// max(count,1) beats, one per cycle without stall, from a rotating entry line.
// The input stalls until the final listing beat is taken.
// Synchronous reset empties the list and returns to idle; entries need no clear.
`default_nettype none

module ordered_list_insert_delete_core #(
   parameter int CAPACITY = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [olid_pkg::CMD_W-1:0]            req_command,
   input  wire logic signed [olid_pkg::DATA_W-1:0]    req_value,
   input  wire logic [olid_pkg::POS_W-1:0]            req_position,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [olid_pkg::DATA_W-1:0]         rsp_element,
   output logic                                       rsp_list_empty,
   output logic                                       rsp_last,
   output logic [olid_pkg::STATUS_W-1:0]              rsp_status
);
   import olid_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   olid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   olid_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_command    (req_command),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_element    (rsp_element),
      .rsp_list_empty (rsp_list_empty),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

>>> sim/ordered_list_checker.sv
// Checker for the ordered list core: watches both channels, keeps its own copy
// of the list and compares every listing beat with the predicted one.
// Depends on olid_pkg for widths and command and status codes.
module ordered_list_checker #(
   parameter int CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [olid_pkg::CMD_W-1:0]          req_command,
   input  logic signed [olid_pkg::DATA_W-1:0]  req_value,
   input  logic [olid_pkg::POS_W-1:0]          req_position,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [olid_pkg::DATA_W-1:0]  rsp_element,
   input  logic                                rsp_list_empty,
   input  logic                                rsp_last,
   input  logic [olid_pkg::STATUS_W-1:0]       rsp_status,
   output int                                  failures,
   output int                                  pending,
   output int                                  beats_checked,
   output int                                  full_drops,
   output int                                  range_misses,
   output int                                  peak_depth
);
   timeunit 1ns;
   timeprecision 1ps;
   import olid_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] element;
      logic                     list_empty;
      logic                     last;
      logic [STATUS_W-1:0]      status;
   } listing_beat_type;

   logic signed [DATA_W-1:0] held [CAPACITY];
   int                       held_count;
   listing_beat_type         listing_q [$];

   task automatic apply_list_command(input logic [CMD_W-1:0] cmd,
                                     input logic signed [DATA_W-1:0] val,
                                     input logic [POS_W-1:0] pos);
      logic [STATUS_W-1:0] st;
      listing_beat_type    beat;
      int                  i;
      st = ST_DONE;
      if (cmd == OP_INSERT_FRONT || cmd == OP_APPEND) begin
         if (held_count >= CAPACITY) begin
            st = ST_FULL;
            full_drops++;
         end else if (cmd == OP_INSERT_FRONT) begin
            for (i = held_count; i > 0; i--) held[i] = held[i-1];
            held[0] = val;
            held_count++;
         end else begin
            held[held_count] = val;
            held_count++;
         end
      end else if (cmd == OP_DELETE) begin
         if (int'(pos) >= held_count) begin
            st = ST_RANGE;
            range_misses++;
         end else begin
            for (i = int'(pos); i + 1 < held_count; i++) held[i] = held[i+1];
            held_count--;
         end
      end
      if (held_count > peak_depth) peak_depth = held_count;
      if (held_count == 0) begin
         beat.element    = '0;
         beat.list_empty = 1'b1;
         beat.last       = 1'b1;
         beat.status     = st;
         listing_q.push_back(beat);
      end else begin
         for (i = 0; i < held_count; i++) begin
            beat.element    = held[i];
            beat.list_empty = 1'b0;
            beat.last       = (i + 1 == held_count);
            beat.status     = st;
            listing_q.push_back(beat);
         end
      end
   endtask

   always @(posedge clock) begin
      listing_beat_type want;
      if (reset) begin
         held_count    = 0;
         listing_q.delete();
         failures      = 0;
         pending       = 0;
         beats_checked = 0;
         full_drops    = 0;
         range_misses  = 0;
         peak_depth    = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (listing_q.size() == 0) begin
               if (failures < 10)
                  $display("%0t: unexpected beat: element %0d empty %0b last %0b status %0d",
                           $realtime, rsp_element, rsp_list_empty, rsp_last, rsp_status);
               failures++;
            end else begin
               want = listing_q.pop_front();
               if (rsp_element !== want.element || rsp_list_empty !== want.list_empty ||
                   rsp_last !== want.last || rsp_status !== want.status) begin
                  if (failures < 10) begin
                     $display("%0t: beat %0d mismatch: expected element %0d empty %0b",
                              $realtime, beats_checked, want.element, want.list_empty);
                     $display("   last %0b status %0d, got element %0d empty %0b",
                              want.last, want.status, rsp_element, rsp_list_empty);
                     $display("   last %0b status %0d", rsp_last, rsp_status);
                  end
                  failures++;
               end
            end
            beats_checked++;
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            apply_list_command(req_command, req_value, req_position);
         pending = listing_q.size();
      end
   end

endmodule

>>> sim/testbench.sv
// Top of the ordered list core testbench: clock, reset, command stimulus with
// idle and stall phases, and the verdict. Depends on olid_pkg, the core and
// ordered_list_checker, which does all prediction and comparison.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import olid_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int PERIOD       = 12;
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASE_ITEMS  = 25;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic [CMD_W-1:0] OP_UNUSED = 2'd3;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command    = OP_INSERT_FRONT;
   logic signed [DATA_W-1:0] req_value      = '0;
   logic [POS_W-1:0]         req_position   = '0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic signed [DATA_W-1:0] rsp_element;
   logic                     rsp_list_empty;
   logic                     rsp_last;
   logic [STATUS_W-1:0]      rsp_status;

   int failures, pending, beats_checked, full_drops, range_misses, peak_depth;

   int cycles         = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_tickets   = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int commands_sent  = 0;
   int fill           = 0;
   bit growing        = 1'b1;
   int turn_tries     = 0;

   ordered_list_insert_delete_core #(.CAPACITY(CAPACITY)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_element    (rsp_element),
      .rsp_list_empty (rsp_list_empty),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

   ordered_list_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_element    (rsp_element),
      .rsp_list_empty (rsp_list_empty),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status),
      .failures       (failures),
      .pending        (pending),
      .beats_checked  (beats_checked),
      .full_drops     (full_drops),
      .range_misses   (range_misses),
      .peak_depth     (peak_depth)
   );

   always #(PERIOD/2) clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still owed", cycles, pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_tickets) begin
         rsp_stall <= 1'b1;
         hold_seen <= hold_tickets;
         hold_left <= HOLD_CYCLES - 1;
      end else begin
         rsp_stall <= (int'($urandom_range(99, 0)) < recv_stall_pct);
      end
   end

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7, 0))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_cmd(input logic [CMD_W-1:0] cmd,
                           input logic signed [DATA_W-1:0] val,
                           input logic [POS_W-1:0] pos);
      @(negedge clock);
      while (int'($urandom_range(99, 0)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_value    <= val;
      req_position <= pos;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      commands_sent++;
      if ((cmd == OP_INSERT_FRONT || cmd == OP_APPEND) && fill < CAPACITY)
         fill++;
      else if (cmd == OP_DELETE && int'(pos) < fill)
         fill--;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // grow to full and press on it, then shrink to empty and press on that too
   task automatic random_cmd();
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] val;
      logic [POS_W-1:0]         pos;
      val = pick_value();
      pos = POS_W'($urandom_range(15, 0));
      if ($urandom_range(99, 0) < 15)
         cmd = CMD_W'($urandom_range(3, 0));
      else if (growing)
         cmd = $urandom_range(1, 0) ? OP_APPEND : OP_INSERT_FRONT;
      else begin
         cmd = OP_DELETE;
         if (fill > 0) pos = POS_W'($urandom_range(fill - 1, 0));
      end
      send_cmd(cmd, val, pos);
      if ((growing && fill == CAPACITY) || (!growing && fill == 0)) begin
         turn_tries++;
         if (turn_tries >= 3) begin
            growing    = !growing;
            turn_tries = 0;
         end
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: empty-list deletes, unused code, extremes, deletes at front, middle, back and out of range
      send_cmd(OP_DELETE,       '0,           4'd0);
      send_cmd(OP_DELETE,       '0,           4'd15);
      send_cmd(OP_UNUSED,       '1,           4'd15);
      send_cmd(OP_INSERT_FRONT, 32'h8000_0000, 4'd0);
      send_cmd(OP_APPEND,       32'h7fff_ffff, 4'd0);
      send_cmd(OP_INSERT_FRONT, '0,           4'd0);
      send_cmd(OP_APPEND,       '1,           4'd0);
      send_cmd(OP_DELETE,       '0,           4'd4);
      send_cmd(OP_DELETE,       '0,           4'd15);
      send_cmd(OP_UNUSED,       32'd5,        4'd0);
      send_cmd(OP_DELETE,       '0,           4'd3);
      send_cmd(OP_DELETE,       '0,           4'd1);
      send_cmd(OP_DELETE,       '0,           4'd0);
      send_cmd(OP_DELETE,       '0,           4'd0);
      send_cmd(OP_APPEND,       32'h5a5a_5a5a, 4'd0);
      send_cmd(OP_INSERT_FRONT, 32'ha5a5_a5a5, 4'd0);
      send_cmd(OP_DELETE,       '0,           4'd1);
      send_cmd(OP_DELETE,       '0,           4'd0);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 70; end
            default: begin send_idle_pct = 13; recv_stall_pct <= 13; end
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 0 && k == 5) hold_tickets <= hold_tickets + 1;
            random_cmd();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d commands and %0d listing beats: %0d full-list drops,",
               commands_sent, beats_checked, full_drops);
      $display("%0d out-of-range deletes, list depth up to %0d of %0d entries",
               range_misses, peak_depth, CAPACITY);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
